FILE: design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; clock and reset names default to clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// explicit clock and active-low reset
`define TPQ_ASSERT_CLK(name, ck, rst_n, prop, msg) \
	name: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// house clock and reset
`define TPQ_ASSERT(name, prop, msg) `TPQ_ASSERT_CLK(name, clk, arst_n, prop, msg)

`endif

FILE: design/tpq_pkg.sv
// shared types, codes and constants of the three-level priority queue
// no dependencies
package tpq_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int ID_W            = 6;
	localparam int Q_DEPTH         = 2;
	localparam int NUM_LEVELS      = 3;

	// request codes
	localparam logic [2:0] RQ_ADD    = 3'd0;
	localparam logic [2:0] RQ_DEMOTE = 3'd1;
	localparam logic [2:0] RQ_NEXT   = 3'd2;
	localparam logic [2:0] RQ_QUERY  = 3'd3;
	localparam logic [2:0] RQ_LIST   = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_BAD_LEVEL = 3'd2;
	localparam logic [2:0] ST_ABSENT    = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_NO_DONE   = 3'd5;

	typedef struct packed {
		logic [2:0]      req_type;
		logic [ID_W-1:0] entry_id;
		logic [2:0]      level;
	} req_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] result_id;
		logic [1:0]      result_level;
		logic            last;
	} rsp_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [2:0]      req_type;
		logic [ID_W-1:0] entry_id;
		logic [1:0]      lvl;
		logic            held;
		logic            lvl_ok;
	} cmd_t;

endpackage

FILE: design/tpq_ram.sv
// generic single write port ram with registered read
// no dependencies
module tpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/tpq_fifo.sv
// small flop-based fifo with show-ahead read
// no dependencies
module tpq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

FILE: design/tpq_front.sv
// front end: accepts requests, classifies them and queues them for the back end
// depends on tpq_pkg and tpq_fifo
module tpq_front #(
	parameter int MAX_ENTRIES = tpq_pkg::MAX_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tpq_pkg::req_t req,
	input  logic          hold,
	output logic          full,
	output logic          cmd_valid,
	output tpq_pkg::cmd_t cmd,
	input  logic          cmd_pop
);

	tpq_pkg::cmd_t                  cls;
	logic                           q_full, q_empty, known;
	logic [$bits(tpq_pkg::cmd_t)-1:0] q_rdata;

	always_comb begin
		cls.req_type = req.req_type;
		cls.entry_id = req.entry_id;
		cls.lvl      = req.level[1:0];
		cls.held     = ({26'd0, req.entry_id} < 32'(MAX_ENTRIES));
		cls.lvl_ok   = req.level inside {[3'd1:3'd3]};
	end

	// unknown request types are taken and dropped
	assign known     = (req.req_type <= tpq_pkg::RQ_LIST);
	assign full      = q_full || hold;
	assign cmd_valid = !q_empty;
	assign cmd       = tpq_pkg::cmd_t'(q_rdata);

	tpq_fifo #(
		.WIDTH ($bits(tpq_pkg::cmd_t)),
		.DEPTH (tpq_pkg::Q_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !full && known),
		.wdata  (cls),
		.full   (q_full),
		.pop    (cmd_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

endmodule

FILE: design/tpq_back.sv
// back end: sequencer over level/done/link rams, list ends and counts
// depends on tpq_pkg and tpq_ram
module tpq_back #(
	parameter int MAX_ENTRIES = tpq_pkg::MAX_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  tpq_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          out_full,
	output logic          out_push,
	output tpq_pkg::rsp_t out_item,
	output logic          clearing
);

	localparam int IW    = $clog2(MAX_ENTRIES);
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int IDW   = tpq_pkg::ID_W;
	localparam int NLV   = tpq_pkg::NUM_LEVELS;
	localparam int NSCAN = (MAX_ENTRIES < (1 << IDW)) ? MAX_ENTRIES : (1 << IDW);

	localparam logic [2:0] S_CLR      = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_EXEC     = 3'd2;
	localparam logic [2:0] S_PUSH     = 3'd3;
	localparam logic [2:0] S_SCAN_RD  = 3'd4;
	localparam logic [2:0] S_SCAN_EV  = 3'd5;
	localparam logic [2:0] S_SCAN_END = 3'd6;

	logic [2:0]    st_q, st_d;
	tpq_pkg::cmd_t op_q, op_d;
	logic [IW-1:0] tgt_q, tgt_d, sc_q, sc_d, pend_q, pend_d, clr_q, clr_d;
	logic [1:0]    li_q, li_d;
	logic          pend_v_q, pend_v_d;
	logic [IW-1:0] se_q [NLV];
	logic [IW-1:0] se_d [NLV];
	logic [IW-1:0] je_q [NLV];
	logic [IW-1:0] je_d [NLV];
	logic [CW-1:0] cnt_q [NLV];
	logic [CW-1:0] cnt_d [NLV];

	logic          lvl_we, done_we, ls_we, lj_we;
	logic [IW-1:0] lvl_wa, done_wa, ls_wa, lj_wa, ls_wd, lj_wd, lk_ra;
	logic [1:0]    lvl_wd, lvl_rd, cur;
	logic          done_wd, done_rd;
	logic [IW-1:0] lk_s, lk_j;
	logic [1:0]    lx, top;
	logic          any;

	assign clearing = (st_q == S_CLR);
	assign any      = (cnt_q[0] != '0) || (cnt_q[1] != '0) || (cnt_q[2] != '0);
	assign top      = (cnt_q[2] != '0) ? 2'd2 : ((cnt_q[1] != '0) ? 2'd1 : 2'd0);
	assign cur      = op_q.held ? lvl_rd : 2'd0;

	always_comb begin
		st_d     = st_q;
		op_d     = op_q;
		tgt_d    = tgt_q;
		li_d     = li_q;
		sc_d     = sc_q;
		pend_d   = pend_q;
		pend_v_d = pend_v_q;
		clr_d    = clr_q;
		se_d     = se_q;
		je_d     = je_q;
		cnt_d    = cnt_q;
		lvl_we   = 1'b0;
		lvl_wa   = tgt_q;
		lvl_wd   = 2'd0;
		done_we  = 1'b0;
		done_wa  = tgt_q;
		done_wd  = 1'b0;
		ls_we    = 1'b0;
		ls_wa    = '0;
		ls_wd    = '0;
		lj_we    = 1'b0;
		lj_wa    = '0;
		lj_wd    = '0;
		cmd_pop  = 1'b0;
		out_push = 1'b0;
		out_item = '0;
		lx       = li_q;
		case (st_q)
			S_CLR: begin
				lvl_we  = 1'b1;
				lvl_wa  = clr_q;
				done_we = 1'b1;
				done_wa = clr_q;
				if (clr_q == IW'(MAX_ENTRIES - 1)) begin
					st_d = S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			S_IDLE: begin
				lx = top;
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					op_d    = cmd;
					if (cmd.req_type == tpq_pkg::RQ_LIST) begin
						sc_d     = '0;
						pend_v_d = 1'b0;
						st_d     = S_SCAN_RD;
					end else if (cmd.req_type == tpq_pkg::RQ_NEXT) begin
						tgt_d = se_q[top];
						li_d  = top;
						st_d  = S_EXEC;
					end else begin
						tgt_d = IW'(cmd.entry_id);
						st_d  = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				if (!out_full) begin
					out_push      = 1'b1;
					out_item.last = 1'b1;
					st_d          = S_IDLE;
					case (op_q.req_type)
						tpq_pkg::RQ_ADD: begin
							lx = op_q.lvl - 2'd1;
							if (!op_q.held) begin
								out_item.status = tpq_pkg::ST_ABSENT;
							end else if (cur != 2'd0) begin
								out_item.status = tpq_pkg::ST_DUP;
							end else if (!op_q.lvl_ok) begin
								out_item.status = tpq_pkg::ST_BAD_LEVEL;
							end else begin
								lvl_we = 1'b1;
								lvl_wd = op_q.lvl;
								// join end append
								if (cnt_q[lx] == '0) begin
									se_d[lx] = tgt_q;
								end else begin
									lj_we = 1'b1;
									lj_wa = je_q[lx];
									lj_wd = tgt_q;
									ls_we = 1'b1;
									ls_wa = tgt_q;
									ls_wd = je_q[lx];
								end
								je_d[lx]  = tgt_q;
								cnt_d[lx] = cnt_q[lx] + 1'b1;
							end
						end
						tpq_pkg::RQ_DEMOTE, tpq_pkg::RQ_NEXT: begin
							lx = (op_q.req_type == tpq_pkg::RQ_NEXT) ? li_q :
								((cur == 2'd0) ? 2'd0 : cur - 2'd1);
							if (op_q.req_type == tpq_pkg::RQ_DEMOTE && cur == 2'd0) begin
								out_item.status = tpq_pkg::ST_ABSENT;
							end else if (op_q.req_type == tpq_pkg::RQ_NEXT && !any) begin
								out_item.status = tpq_pkg::ST_EMPTY;
							end else begin
								// unlink from its level
								if (cnt_q[lx] <= CW'(1)) begin
									cnt_d[lx] = '0;
								end else begin
									if (se_q[lx] == tgt_q) begin
										se_d[lx] = lk_j;
									end else if (je_q[lx] == tgt_q) begin
										je_d[lx] = lk_s;
									end else begin
										lj_we = 1'b1;
										lj_wa = lk_s;
										lj_wd = lk_j;
										ls_we = 1'b1;
										ls_wa = lk_j;
										ls_wd = lk_s;
									end
									cnt_d[lx] = cnt_q[lx] - 1'b1;
								end
								lvl_we = 1'b1;
								if (op_q.req_type == tpq_pkg::RQ_NEXT) begin
									out_item.result_id = IDW'(tgt_q);
								end else if (cur == 2'd1) begin
									done_we = 1'b1;
									done_wd = 1'b1;
								end else begin
									lvl_wd = cur - 2'd1;
									li_d   = cur - 2'd2;
									st_d   = S_PUSH;
								end
							end
						end
						tpq_pkg::RQ_QUERY: begin
							if (cur == 2'd0) begin
								out_item.status = tpq_pkg::ST_ABSENT;
							end else begin
								out_item.result_level = cur;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_PUSH: begin
				// serve end insert at the lower level
				if (cnt_q[lx] == '0) begin
					je_d[lx] = tgt_q;
				end else begin
					ls_we = 1'b1;
					ls_wa = se_q[lx];
					ls_wd = tgt_q;
					lj_we = 1'b1;
					lj_wa = tgt_q;
					lj_wd = se_q[lx];
				end
				se_d[lx]  = tgt_q;
				cnt_d[lx] = cnt_q[lx] + 1'b1;
				st_d      = S_IDLE;
			end
			S_SCAN_RD: begin
				st_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				// one found id is held back so the final one can carry last
				if (!(done_rd && pend_v_q && out_full)) begin
					if (done_rd) begin
						if (pend_v_q) begin
							out_push           = 1'b1;
							out_item.result_id = IDW'(pend_q);
						end
						pend_d   = sc_q;
						pend_v_d = 1'b1;
					end
					if (sc_q == IW'(NSCAN - 1)) begin
						st_d = S_SCAN_END;
					end else begin
						sc_d = sc_q + 1'b1;
						st_d = S_SCAN_RD;
					end
				end
			end
			S_SCAN_END: begin
				if (!out_full) begin
					out_push      = 1'b1;
					out_item.last = 1'b1;
					if (pend_v_q) begin
						out_item.result_id = IDW'(pend_q);
					end else begin
						out_item.status = tpq_pkg::ST_NO_DONE;
					end
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
		lk_ra = tgt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLR;
			clr_q    <= '0;
			pend_v_q <= 1'b0;
			for (int i = 0; i < NLV; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			st_q     <= st_d;
			clr_q    <= clr_d;
			pend_v_q <= pend_v_d;
			cnt_q    <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		tgt_q  <= tgt_d;
		li_q   <= li_d;
		sc_q   <= sc_d;
		pend_q <= pend_d;
		se_q   <= se_d;
		je_q   <= je_d;
	end

	tpq_ram #(.WIDTH(2), .DEPTH(MAX_ENTRIES)) u_lvl_ram (
		.clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd),
		.raddr(tgt_d), .rdata(lvl_rd)
	);

	tpq_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_done_ram (
		.clk(clk), .we(done_we), .waddr(done_wa), .wdata(done_wd),
		.raddr(sc_d), .rdata(done_rd)
	);

	tpq_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_ls_ram (
		.clk(clk), .we(ls_we), .waddr(ls_wa), .wdata(ls_wd),
		.raddr(lk_ra), .rdata(lk_s)
	);

	tpq_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_lj_ram (
		.clk(clk), .we(lj_we), .waddr(lj_wa), .wdata(lj_wd),
		.raddr(lk_ra), .rdata(lk_j)
	);

endmodule

FILE: design/three_level_priority_queue_demotion.sv
// channel   | handshake       | payload
// request   | push / full     | req (req_type, entry_id, level)
// response  | pop / empty     | rsp (status, result_id, result_level, last)
//
// add, take next, query and errors pass IDLE and EXEC in the back end; a demote to a
// lower level also passes PUSH (read, unlink, serve-end insert on the link rams)
// list done reads and checks the done bitmap id by id, one result per done id
// after reset a clearing pass writes every address of the level and done rams
// with full held high
// a full response queue stalls the back end; the request queue accepts until full
// top level: depends on tpq_pkg, tpq_front, tpq_back, tpq_fifo
module three_level_priority_queue_demotion #(
	parameter int MAX_ENTRIES = tpq_pkg::MAX_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  tpq_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output tpq_pkg::rsp_t rsp
);

	tpq_pkg::cmd_t                    cmd;
	tpq_pkg::rsp_t                    out_item;
	logic                             cmd_valid, cmd_pop, out_push, out_full, clearing;
	logic [$bits(tpq_pkg::rsp_t)-1:0] oq_rdata;

	assign rsp = tpq_pkg::rsp_t'(oq_rdata);

	tpq_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.req       (req),
		.hold      (clearing),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tpq_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_item),
		.clearing  (clearing)
	);

	tpq_fifo #(
		.WIDTH ($bits(tpq_pkg::rsp_t)),
		.DEPTH (tpq_pkg::Q_DEPTH)
	) u_rspq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_item),
		.full   (out_full),
		.pop    (pop),
		.rdata  (oq_rdata),
		.empty  (empty)
	);

endmodule

FILE: design/tpq_checker.sv
// port-level checker for the priority queue, bound to the top level
// depends on tpq_pkg and assert_macros.svh
`include "assert_macros.svh"

module tpq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          empty,
	input logic          pop,
	input tpq_pkg::rsp_t rsp
);

	logic is_err;

	assign is_err = !empty && (rsp.status != tpq_pkg::ST_OK);

	`TPQ_ASSERT(a_err_single, is_err |-> rsp.last, "error not last")
	`TPQ_ASSERT(a_err_clean, is_err |-> rsp.result_id == '0 && rsp.result_level == 2'd0, "error payload")
	`TPQ_ASSERT(a_query_form, !empty && rsp.result_level != 2'd0 |-> rsp.result_id == '0 && rsp.last, "query form")
	`TPQ_ASSERT(a_rsp_hold, !empty && !pop |=> !empty && $stable(rsp), "stalled transaction changed")

endmodule

bind three_level_priority_queue_demotion tpq_checker u_tpq_checker (.*);

FILE: test/tb_three_level_priority_queue_demotion.sv
// testbench of the three-level priority queue with demotion
// depends on tpq_pkg and three_level_priority_queue_demotion; predicts every response in-bench
module tb_three_level_priority_queue_demotion;

	localparam int NIDS = 64;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	tpq_pkg::req_t req = '0;
	tpq_pkg::rsp_t rsp;

	three_level_priority_queue_demotion dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req(req), .empty(empty), .pop(pop), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// predicted queue contents: per level an ordered list, serve end at index 0
	logic [1:0]    lvl_of [NIDS];
	logic          done_of [NIDS];
	logic [5:0]    level_list [3][$];
	tpq_pkg::rsp_t pending_rsp [$];
	bit            failed = 1'b0;
	bit            quiet = 1'b0;
	int            cycles = 0;

	function automatic void drop_id(logic [5:0] id, int li);
		for (int k = 0; k < level_list[li].size(); k++)
			if (level_list[li][k] == id) begin
				level_list[li].delete(k);
				return;
			end
	endfunction

	function automatic void join_level(int li, logic [5:0] id);
		level_list[li].insert(level_list[li].size(), id);
	endfunction

	function automatic void note_rsp(tpq_pkg::rsp_t o);
		pending_rsp.insert(pending_rsp.size(), o);
	endfunction

	function automatic void predict_req(tpq_pkg::req_t r);
		tpq_pkg::rsp_t o;
		logic [1:0] cur;
		bit any;
		o = '0;
		o.last = 1'b1;
		cur = lvl_of[r.entry_id];
		case (r.req_type)
			tpq_pkg::RQ_ADD: begin
				if (cur != 2'd0) o.status = tpq_pkg::ST_DUP;
				else if (r.level < 3'd1 || r.level > 3'd3) o.status = tpq_pkg::ST_BAD_LEVEL;
				else begin
					lvl_of[r.entry_id] = r.level[1:0];
					join_level(int'(r.level) - 1, r.entry_id);
					o.status = tpq_pkg::ST_OK;
				end
				note_rsp(o);
			end
			tpq_pkg::RQ_DEMOTE: begin
				if (cur == 2'd0) o.status = tpq_pkg::ST_ABSENT;
				else begin
					drop_id(r.entry_id, int'(cur) - 1);
					if (cur == 2'd1) begin
						lvl_of[r.entry_id] = 2'd0;
						done_of[r.entry_id] = 1'b1;
					end else begin
						lvl_of[r.entry_id] = cur - 2'd1;
						level_list[int'(cur) - 2].push_front(r.entry_id);
					end
				end
				note_rsp(o);
			end
			tpq_pkg::RQ_NEXT: begin
				o.status = tpq_pkg::ST_EMPTY;
				for (int li = 2; li >= 0; li--)
					if (level_list[li].size() != 0) begin
						o.status = tpq_pkg::ST_OK;
						o.result_id = level_list[li].pop_front();
						lvl_of[o.result_id] = 2'd0;
						break;
					end
				note_rsp(o);
			end
			tpq_pkg::RQ_QUERY: begin
				if (cur == 2'd0) o.status = tpq_pkg::ST_ABSENT;
				else o.result_level = cur;
				note_rsp(o);
			end
			tpq_pkg::RQ_LIST: begin
				any = 1'b0;
				for (int i = 0; i < NIDS; i++)
					if (done_of[i]) begin
						o = '0;
						o.result_id = 6'(i);
						note_rsp(o);
						any = 1'b1;
					end
				if (any) pending_rsp[$].last = 1'b1;
				else begin
					o = '0;
					o.status = tpq_pkg::ST_NO_DONE;
					o.last = 1'b1;
					note_rsp(o);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic bit idle_now();
		return !quiet && ($urandom_range(99) < 12);
	endfunction

	// push stays high between back-to-back transactions, dropped only while idling
	task automatic send_req(logic [2:0] t, logic [5:0] id, logic [2:0] lv);
		tpq_pkg::req_t r;
		r.req_type = t;
		r.entry_id = id;
		r.level = lv;
		while (idle_now()) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_req(r);
	endtask

	// response checker
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t response expected none actual %h", $time, rsp);
				failed = 1'b1;
			end else begin
				tpq_pkg::rsp_t e;
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status)
					$display("%0t status expected %0d actual %0d", $time, e.status, rsp.status);
				if (rsp.result_id !== e.result_id)
					$display("%0t id expected %0d actual %0d", $time, e.result_id,
						rsp.result_id);
				if (rsp.result_level !== e.result_level)
					$display("%0t level expected %0d actual %0d", $time, e.result_level,
						rsp.result_level);
				if (rsp.last !== e.last)
					$display("%0t last expected %0d actual %0d", $time, e.last, rsp.last);
				if (rsp !== e) failed = 1'b1;
			end
		end
		pop <= !idle_now();
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_directed();
		send_req(tpq_pkg::RQ_NEXT, 6'd0, 3'd0);
		send_req(tpq_pkg::RQ_LIST, 6'd0, 3'd0);
		send_req(tpq_pkg::RQ_ADD, 6'd0, 3'd0);
		send_req(tpq_pkg::RQ_ADD, 6'd63, 3'd7);
		send_req(tpq_pkg::RQ_ADD, 6'd0, 3'd1);
		send_req(tpq_pkg::RQ_ADD, 6'd63, 3'd3);
		send_req(tpq_pkg::RQ_ADD, 6'd5, 3'd2);
		send_req(tpq_pkg::RQ_ADD, 6'd6, 3'd3);
		send_req(tpq_pkg::RQ_ADD, 6'd0, 3'd5);
		send_req(tpq_pkg::RQ_QUERY, 6'd63, 3'd0);
		send_req(tpq_pkg::RQ_QUERY, 6'd7, 3'd0);
		send_req(tpq_pkg::RQ_DEMOTE, 6'd6, 3'd0);
		send_req(tpq_pkg::RQ_DEMOTE, 6'd0, 3'd0);
		send_req(tpq_pkg::RQ_DEMOTE, 6'd9, 3'd0);
		send_req(3'd5, 6'd1, 3'd1);
		send_req(3'd7, 6'd2, 3'd2);
		send_req(tpq_pkg::RQ_NEXT, 6'd0, 3'd0);
		send_req(tpq_pkg::RQ_NEXT, 6'd0, 3'd0);
		send_req(tpq_pkg::RQ_NEXT, 6'd0, 3'd0);
		send_req(tpq_pkg::RQ_NEXT, 6'd0, 3'd0);
		send_req(tpq_pkg::RQ_ADD, 6'd0, 3'd2);
		send_req(tpq_pkg::RQ_LIST, 6'd0, 3'd0);
	endtask

	// mostly adds and demotes over a small id pool so that levels fill and drain
	task automatic test_random(int n);
		int pick;
		logic [5:0] id;
		for (int i = 0; i < n; i++) begin
			quiet = (i >= n / 2 && i < n / 2 + 80);
			id = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(15));
			pick = $urandom_range(99);
			if (pick < 35) send_req(tpq_pkg::RQ_ADD, id, ($urandom_range(9) == 0) ?
				3'($urandom) : 3'($urandom_range(3, 1)));
			else if (pick < 60) send_req(tpq_pkg::RQ_DEMOTE, id, 3'($urandom));
			else if (pick < 75) send_req(tpq_pkg::RQ_NEXT, 6'($urandom), 3'($urandom));
			else if (pick < 88) send_req(tpq_pkg::RQ_QUERY, id, 3'($urandom));
			else if (pick < 93) send_req(tpq_pkg::RQ_LIST, 6'($urandom), 3'($urandom));
			else send_req(3'($urandom_range(7, 5)), 6'($urandom), 3'($urandom));
		end
		quiet = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < NIDS; i++) begin
			lvl_of[i] = 2'd0;
			done_of[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(410);
		push <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (!failed && pending_rsp.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
